FILE: rtl/core/mog_pkg.sv
// Package for the motor over-current guard: widths, codes, word and command types.
`timescale 1ns / 1ps
`default_nettype none

package mog_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int COUNT_BITS_DEF = 20;
   localparam int SUM_BITS       = 32;
   localparam int TIME_BITS      = 32;
   localparam int THR_BITS       = 12;
   localparam int OFF_BITS       = 8;
   localparam int WIN_BITS       = 16;
   localparam int DIR_BITS       = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int DIV_STEPS      = SUM_BITS;
   localparam int STEP_BITS      = $clog2(DIV_STEPS);

   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(200);
   localparam logic [OFF_BITS-1:0] OFF_RESET = OFF_BITS'(10);
   localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(70);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REWIND_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_MS = 2'd2;

   localparam logic [DIR_BITS-1:0] DIR_FWD  = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_RWD  = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_STOP = 2'd2;
   localparam logic [DIR_BITS-1:0] DIR_OFF  = 2'd3;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] fwd_current;
      logic [SAMPLE_BITS-1:0] rwd_current;
      logic [TIME_BITS-1:0]   now_ms;
      logic                   switch_pressed;
      logic                   switch_level;
   } req_word_type;

   typedef struct packed {
      logic                   drive_fwd;
      logic                   drive_rwd;
      logic                   led_on;
      logic [SAMPLE_BITS-1:0] avg_fwd;
      logic [SAMPLE_BITS-1:0] avg_rwd;
      logic [DIR_BITS-1:0]    direction;
      logic                   window_closed;
      logic                   tripped;
   } rsp_word_type;

   typedef struct packed {
      logic load;      // latch the request word
      logic accum;     // add samples, test window
      logic div_step;  // one quotient bit on both channels
      logic finish;    // trip check, switch, build result
   } dp_cmd_type;

   typedef struct packed {
      logic close;     // window closes on the word in hand
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/mog_ctrl.sv
// Controller for the motor over-current guard: sequences accumulate, divide and finish.
`timescale 1ns / 1ps
`default_nettype none

module mog_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire mog_pkg::dp_status_type status,
   output mog_pkg::dp_cmd_type      cmd
);
   import mog_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            step_in   = '0;
            state_in  = status.close ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/mog_dpath.sv
// Datapath for the motor over-current guard: sums, window timer, serial divider, motor state.
`timescale 1ns / 1ps
`default_nettype none

module mog_dpath #(
   parameter int COUNT_BITS = mog_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mog_pkg::dp_cmd_type                  cmd,
   output mog_pkg::dp_status_type                    status,
   input  wire mog_pkg::req_word_type                req_word,
   input  wire logic                                 csr_write,
   input  wire logic [mog_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mog_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output mog_pkg::rsp_word_type                     rsp_word
);
   import mog_pkg::*;

   req_word_type            req_ff;
   logic [THR_BITS-1:0]     thr_ff;
   logic [OFF_BITS-1:0]     off_ff;
   logic [WIN_BITS-1:0]     win_ff;
   logic [SUM_BITS-1:0]     fsum_ff, rsum_ff, fsum_in, rsum_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in, divisor_ff;
   logic [TIME_BITS-1:0]    wstart_ff, elapsed;
   logic [SAMPLE_BITS-1:0]  favg_ff, ravg_ff, favg_in, ravg_in;
   logic [DIR_BITS-1:0]     motor_ff, motor_in, want;
   logic                    lamp_ff, lamp_in;
   logic                    close_ff;
   logic [SUM_BITS-1:0]     fquo_ff, rquo_ff, fquo_in, rquo_in;
   logic [COUNT_BITS-1:0]   frem_ff, rrem_ff, frem_in, rrem_in;
   logic [COUNT_BITS:0]     frem_sh, rrem_sh, fsub, rsub;
   logic                    fge, rge;
   logic [SUM_BITS:0]       fadd, radd;
   logic                    trip;
   rsp_word_type            rsp_ff, rsp_in;

   // Accumulate with saturation
   assign fadd    = {1'b0, fsum_ff} + (SUM_BITS + 1)'(req_ff.fwd_current);
   assign radd    = {1'b0, rsum_ff} + (SUM_BITS + 1)'(req_ff.rwd_current);
   assign fsum_in = fadd[SUM_BITS] ? '1 : fadd[SUM_BITS-1:0];
   assign rsum_in = radd[SUM_BITS] ? '1 : radd[SUM_BITS-1:0];
   assign count_in = (&count_ff) ? count_ff : count_ff + 1'b1;

   assign elapsed      = req_ff.now_ms - wstart_ff;
   assign status.close = elapsed > TIME_BITS'(win_ff);

   // Restoring division, one bit per cycle on each channel
   assign frem_sh = {frem_ff, fquo_ff[SUM_BITS-1]};
   assign rrem_sh = {rrem_ff, rquo_ff[SUM_BITS-1]};
   assign fge     = frem_sh >= {1'b0, divisor_ff};
   assign rge     = rrem_sh >= {1'b0, divisor_ff};
   assign fsub    = frem_sh - {1'b0, divisor_ff};
   assign rsub    = rrem_sh - {1'b0, divisor_ff};
   assign frem_in = fge ? fsub[COUNT_BITS-1:0] : frem_sh[COUNT_BITS-1:0];
   assign rrem_in = rge ? rsub[COUNT_BITS-1:0] : rrem_sh[COUNT_BITS-1:0];
   assign fquo_in = {fquo_ff[SUM_BITS-2:0], fge};
   assign rquo_in = {rquo_ff[SUM_BITS-2:0], rge};

   // Clamp quotients to the sample range when a window closed
   always_comb begin
      favg_in = favg_ff;
      ravg_in = ravg_ff;
      if (close_ff) begin
         favg_in = (|fquo_ff[SUM_BITS-1:SAMPLE_BITS]) ? '1 : fquo_ff[SAMPLE_BITS-1:0];
         ravg_in = (|rquo_ff[SUM_BITS-1:SAMPLE_BITS]) ? '1 : rquo_ff[SAMPLE_BITS-1:0];
      end
   end

   assign trip = (favg_in > thr_ff)
              || ((THR_BITS + 1)'(ravg_in) > ((THR_BITS + 1)'(thr_ff) + (THR_BITS + 1)'(off_ff)));
   assign want = req_ff.switch_level ? DIR_FWD : DIR_RWD;

   always_comb begin
      motor_in = trip ? DIR_STOP : motor_ff;
      lamp_in  = trip ? 1'b0 : lamp_ff;
      if (req_ff.switch_pressed && (motor_in != want)) begin
         motor_in = want;
         lamp_in  = 1'b1;
      end
      rsp_in.drive_fwd     = (motor_in == DIR_FWD);
      rsp_in.drive_rwd     = (motor_in == DIR_RWD);
      rsp_in.led_on        = lamp_in;
      rsp_in.avg_fwd       = favg_in;
      rsp_in.avg_rwd       = ravg_in;
      rsp_in.direction     = motor_in;
      rsp_in.window_closed = close_ff;
      rsp_in.tripped       = trip;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         off_ff    <= OFF_RESET;
         win_ff    <= WIN_RESET;
         fsum_ff   <= '0;
         rsum_ff   <= '0;
         count_ff  <= '0;
         wstart_ff <= '0;
         favg_ff   <= '0;
         ravg_ff   <= '0;
         motor_ff  <= DIR_OFF;
         lamp_ff   <= 1'b0;
         close_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_THRESHOLD:     thr_ff <= csr_wdata[THR_BITS-1:0];
               CSR_REWIND_OFFSET: off_ff <= csr_wdata[OFF_BITS-1:0];
               CSR_WINDOW_MS:     win_ff <= csr_wdata[WIN_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.accum) begin
            close_ff <= status.close;
            if (status.close) begin
               fsum_ff   <= '0;
               rsum_ff   <= '0;
               count_ff  <= '0;
               wstart_ff <= req_ff.now_ms;
            end else begin
               fsum_ff  <= fsum_in;
               rsum_ff  <= rsum_in;
               count_ff <= count_in;
            end
         end
         if (cmd.finish) begin
            favg_ff  <= favg_in;
            ravg_ff  <= ravg_in;
            motor_ff <= motor_in;
            lamp_ff  <= lamp_in;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.accum) begin
         fquo_ff    <= fsum_in;
         rquo_ff    <= rsum_in;
         frem_ff    <= '0;
         rrem_ff    <= '0;
         divisor_ff <= count_in;
      end else if (cmd.div_step) begin
         fquo_ff <= fquo_in;
         rquo_ff <= rquo_in;
         frem_ff <= frem_in;
         rrem_ff <= rrem_in;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/motor_overcurrent_guard.sv
// Top level of the motor over-current guard: controller and datapath.
//
//   channel  direction  handshake              word
//   req      in         req_valid/req_ready    mog_pkg::req_word_type
//   rsp      out        rsp_valid/rsp_ready    mog_pkg::rsp_word_type
//   csr      in         csr_write (no wait)    csr_index, csr_wdata
//
// A word that closes no window passes from the accept through the accumulate
// and finish states; one that closes a window also passes through the divide
// state, where the bit-serial divider produces both averages for the result.
// The result sits in an output register, so a new word is taken while the
// previous result waits; that word then holds in its last cycle until the
// waiting result is taken. Reset is synchronous; configuration returns to
// 200 / 10 / 70 and the motor to off.
`timescale 1ns / 1ps
`default_nettype none

module motor_overcurrent_guard #(
   parameter int COUNT_BITS = mog_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire mog_pkg::req_word_type                req_word,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output mog_pkg::rsp_word_type                     rsp_word,
   input  wire logic                                 csr_write,
   input  wire logic [mog_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mog_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import mog_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mog_dpath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
